/* design/ist_pkg.sv */
package ist_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ELEM_W = 32;
	localparam int OP_W = 2;
	localparam int RES_CNT_W = 5;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	typedef logic [OP_W-1:0] op_t;
	typedef logic [ELEM_W-1:0] element_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CAPACITY-1:0] slot_vec_t;

	// was_member in bit 0, count in bits 5:1, is_empty in bit 6, status in bit 7
	typedef struct packed {
		logic status;
		logic is_empty;
		logic [RES_CNT_W-1:0] count;
		logic was_member;
	} result_t;

	typedef struct packed {
		logic exec;
	} cmd_t;

endpackage

/* design/ist_ctrl.sv */
module ist_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output ist_pkg::cmd_t cmd
);
	import ist_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_HOLD = 1'b1;

	logic state_q;
	logic state_d;

	assign m_tvalid = (state_q == ST_HOLD);
	assign s_tready = (state_q == ST_IDLE) || m_tready;
	assign cmd.exec = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.exec) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (cmd.exec) state_d = ST_HOLD;
				else if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

/* design/ist_dp.sv */
module ist_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ist_pkg::cmd_t     cmd,
	input  ist_pkg::op_t      operation,
	input  ist_pkg::element_t element,
	output ist_pkg::result_t  result
);
	import ist_pkg::*;

	element_t  value_q [CAPACITY];
	slot_vec_t valid_q;
	cnt_t      count_q;
	result_t   result_q;

	slot_vec_t hit;
	slot_vec_t free_vec;
	slot_vec_t first_free;
	logic      member;
	logic      any_free;
	slot_vec_t valid_d;
	cnt_t      count_d;
	logic      status_d;

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit[i] = valid_q[i] && (value_q[i] == element);
		end
	end

	assign member     = |hit;
	assign free_vec   = ~valid_q;
	assign any_free   = |free_vec;
	assign first_free = free_vec & (~free_vec + slot_vec_t'(1));

	always_comb begin
		valid_d  = valid_q;
		count_d  = count_q;
		status_d = 1'b0;
		case (operation)
			OP_ADD: begin
				if (!member) begin
					if (any_free) begin
						valid_d = valid_q | first_free;
						count_d = count_q + cnt_t'(1);
					end else begin
						status_d = 1'b1;
					end
				end
			end
			OP_REMOVE: begin
				if (member) begin
					valid_d = valid_q & ~hit;
					if (count_q != '0) count_d = count_q - cnt_t'(1);
				end
			end
			OP_CLEAR: begin
				valid_d = '0;
				count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.exec && operation == OP_ADD && !member && first_free[i]) begin
				value_q[i] <= element;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q.was_member <= member;
			result_q.count      <= RES_CNT_W'(count_d);
			result_q.is_empty   <= (count_d == '0);
			result_q.status     <= status_d;
		end
	end

	assign result = result_q;

endmodule

/* design/integer_set_table.sv */
// An accepted transaction's result is registered, valid on the master side next cycle.
// Throughput: one transaction per cycle while m_tready takes each result; all slots are
// compared in parallel and a lowest-free-slot encoder picks the slot for an add.
// Reset: arst_n clears all valid marks, the element count and the output valid;
// no clearing pass, the block accepts transactions as soon as reset is released.
module integer_set_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // element[31:0]
	input  logic [1:0]  s_tuser,  // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // was_member[0], count[5:1], is_empty[6], status[7]
);
	import ist_pkg::*;

	cmd_t    cmd;
	result_t result;

	ist_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ist_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (s_tuser),
		.element   (s_tdata),
		.result    (result)
	);

	assign m_tdata = result;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted transaction left no result");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6] == (m_tdata[5:1] == 5'd0)) || (CAPACITY > 31))
		else $error("empty flag disagrees with count");

	a_full_not_member: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[7] |-> !m_tdata[0] && !m_tdata[6])
		else $error("full status on a present element or empty table");

endmodule
